@@ rtl/thrm_pkg.sv @@
// Package: heap constants, types and sequencer states for the running median block.
package thrm_pkg;
    localparam int HEAP_DEPTH = 1024;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    typedef logic [AW-1:0] t_addr;
    typedef logic [CW-1:0] t_count;

    localparam logic OP_START = 1'b0;
    localparam logic OP_PAIR  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
    } t_req;

    typedef struct packed {
        logic signed [31:0] median;
        logic        overflow;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PLAN,
        S_PUSH_START,
        S_PUSH_RD,
        S_PUSH_WAIT,
        S_PUSH_CMP,
        S_POP_RD,
        S_POP_WAIT,
        S_POP_LAST,
        S_POP_LAST_WAIT,
        S_POP_KIDS,
        S_POP_KIDS_WAIT,
        S_POP_KIDS2,
        S_POP_CMP,
        S_OUT
    } t_state;

    // Heap memory port command between sequencer and a heap store.
    typedef struct packed {
        logic  we;
        t_addr waddr;
        logic signed [31:0] wdata;
        t_addr raddr;
    } t_mem_cmd;
endpackage

@@ rtl/thrm_if.sv @@
// Interfaces: request and result channels.
interface thrm_req_if;
    logic valid;
    logic ready;
    thrm_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface thrm_rsp_if;
    logic valid;
    logic ready;
    thrm_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/thrm_heap_mem.sv @@
// Single heap store: one write and one registered read port.
module thrm_heap_mem (
    input  logic i_clk,
    input  thrm_pkg::t_mem_cmd i_cmd,
    output logic signed [31:0] o_rdata
);
    import thrm_pkg::*;

    logic signed [31:0] r_mem [HEAP_DEPTH];
    logic signed [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_cmd.raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/thrm_seq.sv @@
// Heap sequencer: routes values, sifts up on push, sifts down on pop.
module thrm_seq (
    input  logic i_clk,
    input  logic i_rst_n,
    thrm_req_if.sink  i_req,
    thrm_rsp_if.source o_rsp,
    output thrm_pkg::t_mem_cmd o_lo_cmd,
    output thrm_pkg::t_mem_cmd o_hi_cmd,
    input  logic signed [31:0] i_lo_rdata,
    input  logic signed [31:0] i_hi_rdata
);
    import thrm_pkg::*;

    t_state r_state, n_state;
    t_count r_lo_cnt, n_lo_cnt, r_hi_cnt, n_hi_cnt;
    logic signed [31:0] r_med, n_med;
    logic signed [31:0] r_a, n_a, r_b, n_b;
    logic r_a_low, n_a_low, r_b_low, n_b_low;
    // queue of pushes: step 0 = a, 1 = b, 2 = median rebalance
    logic [1:0] r_step, n_step;
    logic r_side, n_side;               // 1: lower (max) heap
    logic signed [31:0] r_val, n_val;   // value being sifted
    t_count r_idx, n_idx;               // hole index
    t_count r_n, n_n;                   // size for pop
    logic signed [31:0] r_c0, n_c0;     // left child value
    logic r_ovf, n_ovf;
    logic r_ovalid, n_ovalid;
    logic signed [31:0] r_omed, n_omed;
    logic r_oovf, n_oovf;

    t_mem_cmd n_cmd;
    logic signed [31:0] w_rd;
    t_count w_par, w_l, w_r, w_best;
    logic signed [31:0] w_bestv;
    logic w_take_r, w_l_ok, w_r_ok, w_go_l, w_go_r;
    logic [CW:0] w_sum_lo, w_sum_hi;
    logic [1:0] w_add_lo;

    assign w_rd  = r_side ? i_lo_rdata : i_hi_rdata;
    assign w_par = (r_idx - t_count'(1)) >> 1;
    assign w_l   = t_count'({r_idx, 1'b1});
    assign w_r   = w_l + t_count'(1);
    assign w_add_lo = {1'b0, r_a_low} + {1'b0, r_b_low};
    assign w_sum_lo = {1'b0, r_lo_cnt} + {{(CW-1){1'b0}}, w_add_lo};
    assign w_sum_hi = {1'b0, r_hi_cnt} + {{(CW-1){1'b0}}, 2'd2 - w_add_lo};

    function automatic logic ranks(input logic signed [31:0] x, input logic signed [31:0] y,
                                   input logic is_max);
        ranks = is_max ? (x > y) : (x < y);
    endfunction

    // child choice for sift down: left in r_c0, right in read data
    always_comb begin
        w_l_ok = {1'b0, w_l} < {1'b0, r_n} && r_idx < t_count'(HEAP_DEPTH / 2);
        w_r_ok = {1'b0, w_r} < {1'b0, r_n} && r_idx < t_count'(HEAP_DEPTH / 2);
        w_go_l = w_l_ok && ranks(r_c0, r_val, r_side);
        w_take_r = w_r_ok && ranks(w_rd, w_go_l ? r_c0 : r_val, r_side);
        w_go_r = w_take_r;
        w_best = w_go_r ? w_r : w_l;
        w_bestv = w_go_r ? w_rd : r_c0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lo_cnt <= '0;
            r_hi_cnt <= '0;
            r_med <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lo_cnt <= n_lo_cnt;
            r_hi_cnt <= n_hi_cnt;
            r_med <= n_med;
            r_ovalid <= n_ovalid;
        end
        r_a <= n_a; r_b <= n_b; r_a_low <= n_a_low; r_b_low <= n_b_low;
        r_step <= n_step; r_side <= n_side; r_val <= n_val; r_idx <= n_idx;
        r_n <= n_n; r_c0 <= n_c0; r_ovf <= n_ovf; r_omed <= n_omed;
        r_oovf <= n_oovf;
    end

    // next state and memory commands
    always_comb begin
        n_state = r_state;
        n_lo_cnt = r_lo_cnt; n_hi_cnt = r_hi_cnt; n_med = r_med;
        n_a = r_a; n_b = r_b; n_a_low = r_a_low; n_b_low = r_b_low;
        n_step = r_step; n_side = r_side; n_val = r_val; n_idx = r_idx;
        n_n = r_n; n_c0 = r_c0; n_ovf = r_ovf; n_omed = r_omed;
        n_oovf = r_oovf;
        n_ovalid = r_ovalid;
        n_cmd = '0;
        i_req.ready = 1'b0;
        if (o_rsp.ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid && i_req.ready) begin
                    if (i_req.data.opcode == OP_START) begin
                        n_lo_cnt = '0; n_hi_cnt = '0;
                        n_med = i_req.data.value_a;
                    end else begin
                        n_a = i_req.data.value_a;
                        n_b = i_req.data.value_b;
                        n_a_low = i_req.data.value_a < r_med;
                        n_b_low = i_req.data.value_b < r_med;
                        n_state = S_PLAN;
                    end
                end
            end
            S_PLAN: begin
                if (w_sum_lo > (CW+1)'(HEAP_DEPTH) || w_sum_hi > (CW+1)'(HEAP_DEPTH)) begin
                    n_ovf = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_ovf = 1'b0;
                    n_step = 2'd0;
                    n_side = r_a_low; n_val = r_a;
                    n_state = S_PUSH_START;
                end
            end
            // place value at the end of its heap
            S_PUSH_START: begin
                if (r_side) begin
                    n_idx = r_lo_cnt; n_lo_cnt = r_lo_cnt + t_count'(1);
                end else begin
                    n_idx = r_hi_cnt; n_hi_cnt = r_hi_cnt + t_count'(1);
                end
                n_state = S_PUSH_RD;
            end
            S_PUSH_RD: begin
                if (r_idx == '0) begin
                    n_cmd.we = 1'b1; n_cmd.waddr = t_addr'(r_idx); n_cmd.wdata = r_val;
                    n_state = S_PUSH_CMP;
                end else begin
                    n_cmd.raddr = t_addr'(w_par);
                    n_state = S_PUSH_WAIT;
                end
            end
            S_PUSH_WAIT: begin
                n_cmd.we = 1'b1; n_cmd.waddr = t_addr'(r_idx);
                if (ranks(r_val, w_rd, r_side)) begin
                    n_cmd.wdata = w_rd; n_idx = w_par; n_state = S_PUSH_RD;
                end else begin
                    n_cmd.wdata = r_val; n_state = S_PUSH_CMP;
                end
            end
            // advance to the next push, to the rebalance push, then to the pop or the output
            S_PUSH_CMP: begin
                if (r_step == 2'd0) begin
                    n_step = 2'd1; n_side = r_b_low; n_val = r_b; n_state = S_PUSH_START;
                end else if (r_step == 2'd1 && r_lo_cnt != r_hi_cnt) begin
                    n_step = 2'd2;
                    n_side = r_lo_cnt < r_hi_cnt; n_val = r_med; n_state = S_PUSH_START;
                end else if (r_step == 2'd2) begin
                    n_side = !r_side; n_state = S_POP_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            // pop: read top, then last
            S_POP_RD: begin
                n_cmd.raddr = '0; n_state = S_POP_WAIT;
            end
            S_POP_WAIT: begin
                n_med = w_rd;
                if (r_side) begin
                    n_n = r_lo_cnt - t_count'(1); n_lo_cnt = r_lo_cnt - t_count'(1);
                    n_cmd.raddr = t_addr'(r_lo_cnt - t_count'(1));
                end else begin
                    n_n = r_hi_cnt - t_count'(1); n_hi_cnt = r_hi_cnt - t_count'(1);
                    n_cmd.raddr = t_addr'(r_hi_cnt - t_count'(1));
                end
                n_state = (n_n == '0) ? S_OUT : S_POP_LAST;
            end
            S_POP_LAST: begin
                n_val = w_rd; n_idx = '0; n_state = S_POP_KIDS;
            end
            S_POP_KIDS: begin
                n_cmd.raddr = t_addr'(w_l); n_state = S_POP_KIDS_WAIT;
            end
            S_POP_KIDS_WAIT: begin
                n_c0 = w_rd; n_cmd.raddr = t_addr'(w_r); n_state = S_POP_CMP;
            end
            S_POP_CMP: begin
                n_cmd.we = 1'b1; n_cmd.waddr = t_addr'(r_idx);
                if (w_go_l || w_go_r) begin
                    n_cmd.wdata = w_bestv; n_idx = w_best; n_state = S_POP_KIDS;
                end else begin
                    n_cmd.wdata = r_val; n_state = S_OUT;
                end
            end
            // hold until the output register is free, then load it
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1; n_omed = r_med; n_oovf = r_ovf; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_lo_cmd = r_side ? n_cmd : '0;
    assign o_hi_cmd = r_side ? '0 : n_cmd;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data.median = r_omed;
    assign o_rsp.data.overflow = r_oovf;
endmodule

@@ rtl/two_heap_running_median_top.sv @@
// Top level: running median with two heap memories and a sift sequencer.
//  channel | dir | fields
//  i_req   | in  | opcode, value_a, value_b
//  o_rsp   | out | median, overflow
// A start item is taken in the idle state; a dropped pair is accepted, checked
// and output with the overflow flag. A kept pair is accepted, checked and output,
// with up to three sift-up pushes and at most one sift-down pop in between.
// Reset clears counts and median; heap memories are not cleared.
// A waiting result holds the block in its output state until taken.
module two_heap_running_median_top (
    input logic i_clk,
    input logic i_rst_n,
    thrm_req_if.sink  i_req,
    thrm_rsp_if.source o_rsp
);
    import thrm_pkg::*;

    t_mem_cmd w_lo_cmd, w_hi_cmd;
    logic signed [31:0] w_lo_rd, w_hi_rd;

    thrm_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .o_rsp(o_rsp),
        .o_lo_cmd(w_lo_cmd), .o_hi_cmd(w_hi_cmd),
        .i_lo_rdata(w_lo_rd), .i_hi_rdata(w_hi_rd)
    );
    thrm_heap_mem u_lo (.i_clk(i_clk), .i_cmd(w_lo_cmd), .o_rdata(w_lo_rd));
    thrm_heap_mem u_hi (.i_clk(i_clk), .i_cmd(w_hi_cmd), .o_rdata(w_hi_rd));
endmodule
